// File: hw/rtl/i2cra_pkg.sv
package i2cra_pkg;

  localparam int unsigned DELAY_W = 20;

  typedef logic [1:0] func_t;

  localparam func_t FUNC_TICK  = 2'd0;
  localparam func_t FUNC_WRITE = 2'd1;
  localparam func_t FUNC_READ  = 2'd2;

  typedef logic [1:0] cfg_index_t;

  localparam cfg_index_t CFG_DEVICE_WRITE_ADDRESS = 2'd0;
  localparam cfg_index_t CFG_TICKS_PER_DELAY_UNIT = 2'd1;
  localparam cfg_index_t CFG_ACK_POLL_LIMIT       = 2'd2;

  localparam logic [7:0]  RESET_DEVICE_WRITE_ADDRESS = 8'ha2;
  localparam logic [15:0] RESET_TICKS_PER_DELAY_UNIT = 16'd100;
  localparam logic [7:0]  RESET_ACK_POLL_LIMIT       = 8'd250;

  typedef struct packed {
    logic [7:0]  device_write_address;
    logic [15:0] ticks_per_delay_unit;
    logic [7:0]  ack_poll_limit;
  } cfg_t;

  typedef struct packed {
    func_t      func;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_out;
    logic       sda_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_error;
  } res_t;

endpackage

// File: hw/rtl/i2cra_if.sv
interface i2cra_req_if;
  logic                valid;
  logic                ready;
  i2cra_pkg::func_t    func;
  logic [7:0]          reg_addr;
  logic [7:0]          write_data;
  logic                sda_in;

  modport source (output valid, output func, output reg_addr, output write_data,
                  output sda_in, input ready);
  modport sink (input valid, input func, input reg_addr, input write_data,
                input sda_in, output ready);
endinterface

interface i2cra_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_out;
  logic       sda_enable;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       ack_error;

  modport source (output valid, output scl_level, output sda_out, output sda_enable,
                  output busy_res, output done_res, output read_data, output ack_error,
                  input ready);
  modport sink (input valid, input scl_level, input sda_out, input sda_enable,
                input busy_res, input done_res, input read_data, input ack_error,
                output ready);
endinterface

// File: hw/rtl/i2cra_engine.sv
module i2cra_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  i2cra_pkg::req_t   req,
  input  i2cra_pkg::cfg_t   cfg,
  output i2cra_pkg::res_t   res
);

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_ST_A  = 4'd1;
  localparam logic [3:0] PH_ST_B  = 4'd2;
  localparam logic [3:0] PH_TX_D  = 4'd3;
  localparam logic [3:0] PH_TX_H  = 4'd4;
  localparam logic [3:0] PH_TX_L  = 4'd5;
  localparam logic [3:0] PH_ACK_A = 4'd6;
  localparam logic [3:0] PH_ACK_B = 4'd7;
  localparam logic [3:0] PH_ACK_P = 4'd8;
  localparam logic [3:0] PH_RX_L  = 4'd9;
  localparam logic [3:0] PH_RX_H  = 4'd10;
  localparam logic [3:0] PH_NK_A  = 4'd11;
  localparam logic [3:0] PH_NK_B  = 4'd12;
  localparam logic [3:0] PH_SP_A  = 4'd13;
  localparam logic [3:0] PH_SP_B  = 4'd14;
  localparam logic [3:0] PH_TAIL  = 4'd15;

  localparam int unsigned DW = i2cra_pkg::DELAY_W;

  logic [3:0]    phase, phase_next;
  logic [3:0]    bit_count, bit_count_next;
  logic [7:0]    shift_byte, shift_byte_next;
  logic [DW-1:0] delay_ticks, delay_ticks_next;
  logic [7:0]    poll_count, poll_count_next;
  logic          held_read, held_read_next;
  logic [7:0]    held_reg, held_reg_next;
  logic [7:0]    held_data, held_data_next;
  logic [7:0]    received_byte, received_byte_next;
  logic          error_flag, error_flag_next;
  logic [1:0]    stage, stage_next;
  logic          scl, scl_next;
  logic          sda, sda_next;
  logic          sda_en, sda_en_next;
  logic          done_next;

  logic [3:0]    target;
  logic          do_go;
  logic [DW-1:0] unit, wait_1, wait_2, wait_4, wait_10;

  // zero ticks per unit behaves as one
  assign unit = (cfg.ticks_per_delay_unit == 16'd0) ? DW'(1)
                                                    : DW'(cfg.ticks_per_delay_unit);
  assign wait_1  = unit;
  assign wait_2  = unit << 1;
  assign wait_4  = unit << 2;
  assign wait_10 = (unit << 3) + (unit << 1);

  always_comb begin
    phase_next         = phase;
    bit_count_next     = bit_count;
    shift_byte_next    = shift_byte;
    delay_ticks_next   = delay_ticks;
    poll_count_next    = poll_count;
    held_read_next     = held_read;
    held_reg_next      = held_reg;
    held_data_next     = held_data;
    received_byte_next = received_byte;
    error_flag_next    = error_flag;
    stage_next         = stage;
    scl_next           = scl;
    sda_next           = sda;
    sda_en_next        = sda_en;
    done_next          = 1'b0;
    target             = phase;
    do_go              = 1'b0;

    if (phase == PH_IDLE) begin
      if (req.func == i2cra_pkg::FUNC_WRITE || req.func == i2cra_pkg::FUNC_READ) begin
        held_read_next  = (req.func == i2cra_pkg::FUNC_READ);
        held_reg_next   = req.reg_addr;
        held_data_next  = req.write_data;
        error_flag_next = 1'b0;
        stage_next      = 2'd0;
        bit_count_next  = 4'd0;
        poll_count_next = 8'd0;
        target          = PH_ST_A;
        do_go           = 1'b1;
      end
    end else if (phase == PH_ACK_P) begin
      if (!req.sda_in) begin
        do_go = 1'b1;
        if (stage == 2'd0) begin
          stage_next      = 2'd1;
          shift_byte_next = held_reg;
          bit_count_next  = 4'd0;
          target          = PH_TX_D;
        end else if (stage == 2'd1) begin
          stage_next = 2'd2;
          if (held_read) begin
            target = PH_ST_A;
          end else begin
            shift_byte_next = held_data;
            bit_count_next  = 4'd0;
            target          = PH_TX_D;
          end
        end else if (held_read) begin
          bit_count_next  = 4'd0;
          shift_byte_next = 8'd0;
          target          = PH_RX_L;
        end else begin
          target = PH_SP_A;
        end
      end else if (poll_count >= cfg.ack_poll_limit) begin
        // no acknowledge in time: stop and flag
        error_flag_next = 1'b1;
        target          = PH_SP_A;
        do_go           = 1'b1;
      end else begin
        poll_count_next = poll_count + 8'd1;
      end
    end else if (delay_ticks > DW'(1)) begin
      delay_ticks_next = delay_ticks - DW'(1);
    end else begin
      delay_ticks_next = '0;
      do_go            = 1'b1;
      unique case (phase)
        PH_ST_A: target = PH_ST_B;
        PH_ST_B: begin
          // repeated start sends the read address
          shift_byte_next = (stage == 2'd0) ? cfg.device_write_address
                                            : cfg.device_write_address + 8'd1;
          bit_count_next  = 4'd0;
          target          = PH_TX_D;
        end
        PH_TX_D: target = PH_TX_H;
        PH_TX_H: target = PH_TX_L;
        PH_TX_L: begin
          shift_byte_next = shift_byte << 1;
          bit_count_next  = bit_count + 4'd1;
          target          = (bit_count_next >= 4'd8) ? PH_ACK_A : PH_TX_D;
        end
        PH_ACK_A: target = PH_ACK_B;
        PH_ACK_B: target = PH_ACK_P;
        PH_RX_L:  target = PH_RX_H;
        PH_RX_H: begin
          shift_byte_next = {shift_byte[6:0], req.sda_in};
          bit_count_next  = bit_count + 4'd1;
          target          = (bit_count_next >= 4'd8) ? PH_NK_A : PH_RX_L;
        end
        PH_NK_A: target = PH_NK_B;
        PH_NK_B: target = PH_SP_A;
        PH_SP_A: target = PH_SP_B;
        PH_SP_B: begin
          if (!held_read && !error_flag) begin
            target = PH_TAIL;
          end else begin
            if (held_read && !error_flag) begin
              received_byte_next = shift_byte;
            end
            done_next = 1'b1;
            target    = PH_IDLE;
          end
        end
        PH_TAIL: begin
          done_next = 1'b1;
          target    = PH_IDLE;
        end
        default: target = PH_IDLE;
      endcase
    end

    if (do_go) begin
      phase_next = target;
      unique case (target)
        PH_ST_A: begin
          sda_en_next = 1'b1; sda_next = 1'b1; scl_next = 1'b1;
          delay_ticks_next = wait_4;
        end
        PH_ST_B: begin
          sda_next = 1'b0;
          delay_ticks_next = wait_4;
        end
        PH_TX_D: begin
          sda_en_next = 1'b1; scl_next = 1'b0; sda_next = shift_byte_next[7];
          delay_ticks_next = wait_2;
        end
        PH_TX_H: begin
          scl_next = 1'b1;
          delay_ticks_next = wait_2;
        end
        PH_TX_L: begin
          scl_next = 1'b0;
          delay_ticks_next = wait_2;
        end
        PH_ACK_A: begin
          sda_en_next = 1'b0; sda_next = 1'b1; scl_next = 1'b0;
          delay_ticks_next = wait_1;
        end
        PH_ACK_B: begin
          scl_next = 1'b1;
          delay_ticks_next = wait_1;
        end
        PH_ACK_P: begin
          poll_count_next  = 8'd0;
          delay_ticks_next = '0;
        end
        PH_RX_L: begin
          sda_en_next = 1'b0; scl_next = 1'b0;
          delay_ticks_next = wait_2;
        end
        PH_RX_H: begin
          scl_next = 1'b1;
          delay_ticks_next = wait_1;
        end
        PH_NK_A: begin
          scl_next = 1'b0; sda_en_next = 1'b1; sda_next = 1'b1;
          delay_ticks_next = wait_2;
        end
        PH_NK_B: begin
          scl_next = 1'b1;
          delay_ticks_next = wait_2;
        end
        PH_SP_A: begin
          sda_en_next = 1'b1; scl_next = 1'b0; sda_next = 1'b0;
          delay_ticks_next = wait_4;
        end
        PH_SP_B: begin
          scl_next = 1'b1; sda_next = 1'b1;
          delay_ticks_next = wait_4;
        end
        PH_TAIL: delay_ticks_next = wait_10;
        default: begin
          phase_next = PH_IDLE;
          delay_ticks_next = '0;
          scl_next = 1'b1; sda_next = 1'b1; sda_en_next = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_count     <= 4'd0;
      shift_byte    <= 8'd0;
      delay_ticks   <= '0;
      poll_count    <= 8'd0;
      held_read     <= 1'b0;
      held_reg      <= 8'd0;
      held_data     <= 8'd0;
      received_byte <= 8'd0;
      error_flag    <= 1'b0;
      stage         <= 2'd0;
      scl           <= 1'b1;
      sda           <= 1'b1;
      sda_en        <= 1'b1;
    end else if (step) begin
      phase         <= phase_next;
      bit_count     <= bit_count_next;
      shift_byte    <= shift_byte_next;
      delay_ticks   <= delay_ticks_next;
      poll_count    <= poll_count_next;
      held_read     <= held_read_next;
      held_reg      <= held_reg_next;
      held_data     <= held_data_next;
      received_byte <= received_byte_next;
      error_flag    <= error_flag_next;
      stage         <= stage_next;
      scl           <= scl_next;
      sda           <= sda_next;
      sda_en        <= sda_en_next;
    end
  end

  assign res.scl_level  = scl_next;
  assign res.sda_out    = sda_next;
  assign res.sda_enable = sda_en_next;
  assign res.busy_res   = (phase_next != PH_IDLE);
  assign res.done_res   = done_next;
  assign res.read_data  = received_byte_next;
  assign res.ack_error  = error_flag_next;

endmodule

// File: hw/rtl/i2c_register_access_master.sv
// each accepted request's result is computed combinationally and registered in the output register
// one request per cycle while the result side is ready; the bus state advances once per accepted request,
// all of it done by the step logic between the state registers and the output register
// reset: bus idle with scl, sda and sda enable high, counters and flags cleared,
// configuration back to address 0xa2, 100 ticks per delay unit, 250 acknowledge polls
module i2c_register_access_master (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  i2cra_pkg::cfg_index_t  cfg_index,
  input  logic [15:0]            cfg_data,
  i2cra_req_if.sink              req,
  i2cra_res_if.source            res
);

  i2cra_pkg::cfg_t cfg;
  i2cra_pkg::req_t step_req;
  i2cra_pkg::res_t step_res;
  i2cra_pkg::res_t out_q;
  logic            out_valid;
  logic            accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_write_address <= i2cra_pkg::RESET_DEVICE_WRITE_ADDRESS;
      cfg.ticks_per_delay_unit <= i2cra_pkg::RESET_TICKS_PER_DELAY_UNIT;
      cfg.ack_poll_limit       <= i2cra_pkg::RESET_ACK_POLL_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        i2cra_pkg::CFG_DEVICE_WRITE_ADDRESS: cfg.device_write_address <= cfg_data[7:0];
        i2cra_pkg::CFG_TICKS_PER_DELAY_UNIT: cfg.ticks_per_delay_unit <= cfg_data;
        i2cra_pkg::CFG_ACK_POLL_LIMIT:       cfg.ack_poll_limit       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // output register decouples the two sides
  assign req.ready = !out_valid || res.ready;
  assign accept    = req.valid && req.ready;

  assign step_req.func       = req.func;
  assign step_req.reg_addr   = req.reg_addr;
  assign step_req.write_data = req.write_data;
  assign step_req.sda_in     = req.sda_in;

  i2cra_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .step (accept),
    .req  (step_req),
    .cfg  (cfg),
    .res  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_q <= step_res;
    end
  end

  assign res.valid      = out_valid;
  assign res.scl_level  = out_q.scl_level;
  assign res.sda_out    = out_q.sda_out;
  assign res.sda_enable = out_q.sda_enable;
  assign res.busy_res   = out_q.busy_res;
  assign res.done_res   = out_q.done_res;
  assign res.read_data  = out_q.read_data;
  assign res.ack_error  = out_q.ack_error;

endmodule

// File: sim/i2c_register_access_master_tb.sv
module i2c_register_access_master_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam i2cra_pkg::func_t FUNC_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int NO_FAIL = -1;

  localparam logic [3:0] BUS_IDLE     = 4'd0;
  localparam logic [3:0] BUS_START_A  = 4'd1;
  localparam logic [3:0] BUS_START_B  = 4'd2;
  localparam logic [3:0] BUS_TX_DATA  = 4'd3;
  localparam logic [3:0] BUS_TX_HIGH  = 4'd4;
  localparam logic [3:0] BUS_TX_LOW   = 4'd5;
  localparam logic [3:0] BUS_ACK_A    = 4'd6;
  localparam logic [3:0] BUS_ACK_B    = 4'd7;
  localparam logic [3:0] BUS_ACK_POLL = 4'd8;
  localparam logic [3:0] BUS_RX_LOW   = 4'd9;
  localparam logic [3:0] BUS_RX_HIGH  = 4'd10;
  localparam logic [3:0] BUS_NACK_A   = 4'd11;
  localparam logic [3:0] BUS_NACK_B   = 4'd12;
  localparam logic [3:0] BUS_STOP_A   = 4'd13;
  localparam logic [3:0] BUS_STOP_B   = 4'd14;
  localparam logic [3:0] BUS_TAIL     = 4'd15;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  i2cra_pkg::cfg_index_t  cfg_index;
  logic [15:0]            cfg_data;

  i2cra_req_if req();
  i2cra_res_if res();

  i2c_register_access_master u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .res       (res)
  );

  always #1ns clk = ~clk;

  // bus engine copy, advanced once per accepted request
  logic [7:0]  dev_addr;
  logic [15:0] unit_ticks_cfg;
  logic [7:0]  poll_limit;

  logic [3:0]  bus_phase;
  logic [3:0]  bus_bits;
  logic [7:0]  bus_shift;
  logic [23:0] bus_delay;
  logic [7:0]  bus_polls;
  logic        bus_is_read;
  logic [7:0]  bus_reg;
  logic [7:0]  bus_data;
  logic [7:0]  bus_rx;
  logic        bus_err;
  logic [1:0]  bus_stage;
  logic        bus_scl;
  logic        bus_sda;
  logic        bus_en;
  logic        bus_done;

  i2cra_pkg::res_t predicted_lines[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned req_gap_max = 11;
  int unsigned res_gap_max = 11;
  int unsigned res_wait = 0;
  int unsigned res_pause = 0;

  function automatic void bus_wait(int unsigned units);
    int unsigned unit_ticks;
    unit_ticks = (unit_ticks_cfg == 16'd0) ? 32'd1 : 32'(unit_ticks_cfg);
    bus_delay = 24'(units * unit_ticks);
  endfunction

  function automatic void bus_enter(logic [3:0] ph);
    bus_phase = ph;
    case (ph)
      BUS_START_A: begin bus_en = 1'b1; bus_sda = 1'b1; bus_scl = 1'b1; bus_wait(4); end
      BUS_START_B: begin bus_sda = 1'b0; bus_wait(4); end
      BUS_TX_DATA: begin
        bus_en = 1'b1; bus_scl = 1'b0; bus_sda = bus_shift[7]; bus_wait(2);
      end
      BUS_TX_HIGH: begin bus_scl = 1'b1; bus_wait(2); end
      BUS_TX_LOW: begin bus_scl = 1'b0; bus_wait(2); end
      BUS_ACK_A: begin bus_en = 1'b0; bus_sda = 1'b1; bus_scl = 1'b0; bus_wait(1); end
      BUS_ACK_B: begin bus_scl = 1'b1; bus_wait(1); end
      BUS_ACK_POLL: begin bus_polls = 8'd0; bus_delay = 24'd0; end
      BUS_RX_LOW: begin bus_en = 1'b0; bus_scl = 1'b0; bus_wait(2); end
      BUS_RX_HIGH: begin bus_scl = 1'b1; bus_wait(1); end
      BUS_NACK_A: begin bus_scl = 1'b0; bus_en = 1'b1; bus_sda = 1'b1; bus_wait(2); end
      BUS_NACK_B: begin bus_scl = 1'b1; bus_wait(2); end
      BUS_STOP_A: begin bus_en = 1'b1; bus_scl = 1'b0; bus_sda = 1'b0; bus_wait(4); end
      BUS_STOP_B: begin bus_scl = 1'b1; bus_sda = 1'b1; bus_wait(4); end
      BUS_TAIL: bus_wait(10);
      default: begin
        bus_phase = BUS_IDLE;
        bus_delay = 24'd0;
        bus_scl = 1'b1;
        bus_sda = 1'b1;
        bus_en = 1'b1;
      end
    endcase
  endfunction

  function automatic void bus_send(logic [7:0] value);
    bus_shift = value;
    bus_bits = 4'd0;
    bus_enter(BUS_TX_DATA);
  endfunction

  function automatic void bus_finish();
    if (bus_is_read && !bus_err) bus_rx = bus_shift;
    bus_done = 1'b1;
    bus_enter(BUS_IDLE);
  endfunction

  function automatic void bus_acked();
    bus_scl = 1'b0;
    if (bus_stage == 2'd0) begin
      bus_stage = 2'd1;
      bus_send(bus_reg);
    end else if (bus_stage == 2'd1) begin
      bus_stage = 2'd2;
      // read turns around with a repeated start
      if (bus_is_read) bus_enter(BUS_START_A);
      else bus_send(bus_data);
    end else if (bus_is_read) begin
      bus_bits = 4'd0;
      bus_shift = 8'd0;
      bus_enter(BUS_RX_LOW);
    end else begin
      bus_enter(BUS_STOP_A);
    end
  endfunction

  function automatic void bus_advance(logic sd);
    case (bus_phase)
      BUS_START_A: bus_enter(BUS_START_B);
      BUS_START_B: begin
        bus_scl = 1'b0;
        bus_send(bus_stage == 2'd0 ? dev_addr : 8'(dev_addr + 8'd1));
      end
      BUS_TX_DATA: bus_enter(BUS_TX_HIGH);
      BUS_TX_HIGH: bus_enter(BUS_TX_LOW);
      BUS_TX_LOW: begin
        bus_shift = bus_shift << 1;
        bus_bits = bus_bits + 4'd1;
        bus_enter(bus_bits >= 4'd8 ? BUS_ACK_A : BUS_TX_DATA);
      end
      BUS_ACK_A: bus_enter(BUS_ACK_B);
      BUS_ACK_B: bus_enter(BUS_ACK_POLL);
      BUS_RX_LOW: bus_enter(BUS_RX_HIGH);
      BUS_RX_HIGH: begin
        bus_shift = {bus_shift[6:0], sd};
        bus_bits = bus_bits + 4'd1;
        bus_enter(bus_bits >= 4'd8 ? BUS_NACK_A : BUS_RX_LOW);
      end
      BUS_NACK_A: bus_enter(BUS_NACK_B);
      BUS_NACK_B: begin bus_scl = 1'b0; bus_enter(BUS_STOP_A); end
      BUS_STOP_A: bus_enter(BUS_STOP_B);
      BUS_STOP_B: begin
        if (!bus_is_read && !bus_err) bus_enter(BUS_TAIL);
        else bus_finish();
      end
      BUS_TAIL: bus_finish();
      default: bus_enter(BUS_IDLE);
    endcase
  endfunction

  function automatic void bus_reset();
    dev_addr = i2cra_pkg::RESET_DEVICE_WRITE_ADDRESS;
    unit_ticks_cfg = i2cra_pkg::RESET_TICKS_PER_DELAY_UNIT;
    poll_limit = i2cra_pkg::RESET_ACK_POLL_LIMIT;
    bus_bits = 4'd0;
    bus_shift = 8'd0;
    bus_polls = 8'd0;
    bus_is_read = 1'b0;
    bus_reg = 8'd0;
    bus_data = 8'd0;
    bus_rx = 8'd0;
    bus_err = 1'b0;
    bus_stage = 2'd0;
    bus_done = 1'b0;
    bus_enter(BUS_IDLE);
  endfunction

  function automatic i2cra_pkg::res_t bus_step(i2cra_pkg::func_t f, logic [7:0] ra,
                                               logic [7:0] wd, logic sd);
    i2cra_pkg::res_t lines;
    bus_done = 1'b0;
    if (bus_phase == BUS_IDLE) begin
      if (f == i2cra_pkg::FUNC_WRITE || f == i2cra_pkg::FUNC_READ) begin
        bus_is_read = (f == i2cra_pkg::FUNC_READ);
        bus_reg = ra;
        bus_data = wd;
        bus_err = 1'b0;
        bus_stage = 2'd0;
        bus_bits = 4'd0;
        bus_polls = 8'd0;
        bus_enter(BUS_START_A);
      end
    end else if (bus_phase == BUS_ACK_POLL) begin
      if (!sd) bus_acked();
      else if (bus_polls >= poll_limit) begin
        bus_err = 1'b1;
        bus_enter(BUS_STOP_A);
      end else begin
        bus_polls = bus_polls + 8'd1;
      end
    end else if (bus_delay > 24'd1) begin
      bus_delay = bus_delay - 24'd1;
    end else begin
      bus_delay = 24'd0;
      bus_advance(sd);
    end
    lines.scl_level = bus_scl;
    lines.sda_out = bus_sda;
    lines.sda_enable = bus_en;
    lines.busy_res = (bus_phase != BUS_IDLE);
    lines.done_res = bus_done;
    lines.read_data = bus_rx;
    lines.ack_error = bus_err;
    return lines;
  endfunction

  // one request, with a random hold-off in front of it
  task automatic send_tick(input i2cra_pkg::func_t f, input logic [7:0] ra,
                           input logic [7:0] wd, input logic sd);
    int unsigned gap;
    gap = $urandom_range(0, req_gap_max);
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.func <= f;
    req.reg_addr <= ra;
    req.write_data <= wd;
    req.sda_in <= sd;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predicted_lines.push_back(bus_step(f, ra, wd, sd));
  endtask

  // acts as the device: acks low, except at the stage chosen to time out
  task automatic device_tick(input int fail_stage);
    i2cra_pkg::func_t f;
    logic sd;
    f = i2cra_pkg::FUNC_TICK;
    if ($urandom_range(0, 7) == 0) f = i2cra_pkg::func_t'($urandom_range(0, 3));
    if (bus_phase == BUS_ACK_POLL) begin
      if (fail_stage == int'(bus_stage)) sd = 1'b1;
      else sd = ($urandom_range(0, 3) == 0);
    end else begin
      sd = 1'($urandom_range(0, 1));
    end
    send_tick(f, 8'($urandom), 8'($urandom), sd);
  endtask

  task automatic run_transaction(input i2cra_pkg::func_t f, input logic [7:0] ra,
                                 input logic [7:0] wd, input int fail_stage);
    send_tick(f, ra, wd, 1'($urandom_range(0, 1)));
    while (bus_phase != BUS_IDLE) device_tick(fail_stage);
  endtask

  task automatic idle_noise(input int unsigned n);
    repeat (n) begin
      send_tick($urandom_range(0, 1) ? i2cra_pkg::FUNC_TICK : FUNC_UNUSED,
                8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic settle();
    req.valid <= 1'b0;
    while (predicted_lines.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic cfg_write(input i2cra_pkg::cfg_index_t idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      i2cra_pkg::CFG_DEVICE_WRITE_ADDRESS: dev_addr = value[7:0];
      i2cra_pkg::CFG_TICKS_PER_DELAY_UNIT: unit_ticks_cfg = value;
      i2cra_pkg::CFG_ACK_POLL_LIMIT: poll_limit = value[7:0];
      default: ;
    endcase
  endtask

  // upper data bits are junk for the byte-wide registers
  task automatic set_config(input logic [7:0] addr, input logic [15:0] ticks,
                            input logic [7:0] limit);
    cfg_write(i2cra_pkg::CFG_DEVICE_WRITE_ADDRESS, {8'($urandom), addr});
    cfg_write(i2cra_pkg::CFG_TICKS_PER_DELAY_UNIT, ticks);
    cfg_write(i2cra_pkg::CFG_ACK_POLL_LIMIT, {8'($urandom), limit});
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_tick(i2cra_pkg::FUNC_TICK, 8'h00, 8'h00, 1'b0);
    send_tick(FUNC_UNUSED, 8'hff, 8'hff, 1'b1);
    send_tick(i2cra_pkg::FUNC_TICK, 8'hff, 8'hff, 1'b1);
    send_tick(FUNC_UNUSED, 8'h00, 8'h00, 1'b0);
    settle();
    // only the timing unit changes, address and poll limit stay at reset
    cfg_write(i2cra_pkg::CFG_TICKS_PER_DELAY_UNIT, 16'd1);
    cfg_we <= 1'b0;
    run_transaction(i2cra_pkg::FUNC_WRITE, 8'h00, 8'hff, NO_FAIL);
  endtask

  task automatic test_read_extremes();
    settle();
    // zero ticks per unit acts as one, read address wraps to zero
    set_config(8'd255, 16'd0, 8'd250);
    run_transaction(i2cra_pkg::FUNC_READ, 8'hff, 8'h00, NO_FAIL);
  endtask

  task automatic test_ack_timeout();
    settle();
    // limit zero gives up on the first high poll, no idling on either side
    set_config(8'h00, 16'd1, 8'd0);
    req_gap_max = 0;
    res_gap_max = 0;
    run_transaction(i2cra_pkg::FUNC_WRITE, 8'h12, 8'h34, 0);
    req_gap_max = 11;
    res_gap_max = 11;
    settle();
    // failed read keeps the previous read byte
    set_config(8'ha2, 16'd1, 8'd2);
    run_transaction(i2cra_pkg::FUNC_READ, 8'h3c, 8'h00, 1);
  endtask

  task automatic test_backpressure();
    settle();
    req_gap_max = 0;
    res_pause = 40;
    idle_noise(12);
    req_gap_max = 11;
  endtask

  task automatic test_slow_timing();
    settle();
    // longest delay unit, only the opening of the transaction fits in the run
    set_config(8'ha2, 16'hffff, 8'd250);
    send_tick(i2cra_pkg::FUNC_WRITE, 8'h5a, 8'ha5, 1'b0);
    repeat (40) device_tick(NO_FAIL);
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    i2cra_pkg::res_t want;
    if (!rst && res.valid && res.ready) begin
      if (predicted_lines.size() == 0) begin
        $error("result with nothing predicted");
        error_count++;
      end else begin
        want = predicted_lines.pop_front();
        check_field("scl_level", 8'(want.scl_level), 8'(res.scl_level));
        check_field("sda_out", 8'(want.sda_out), 8'(res.sda_out));
        check_field("sda_enable", 8'(want.sda_enable), 8'(res.sda_enable));
        check_field("busy_res", 8'(want.busy_res), 8'(res.busy_res));
        check_field("done_res", 8'(want.done_res), 8'(res.done_res));
        check_field("read_data", want.read_data, res.read_data);
        check_field("ack_error", 8'(want.ack_error), 8'(res.ack_error));
      end
    end
  end

  // result side stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) res_wait = $urandom_range(0, res_gap_max);
      if (res_pause > 0) begin
        res_pause--;
        res.ready <= 1'b0;
      end else if (res_wait > 0) begin
        res_wait--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= i2cra_pkg::CFG_DEVICE_WRITE_ADDRESS;
    cfg_data <= 16'd0;
    req.valid <= 1'b0;
    req.func <= i2cra_pkg::FUNC_TICK;
    req.reg_addr <= 8'd0;
    req.write_data <= 8'd0;
    req.sda_in <= 1'b0;
    bus_reset();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_read_extremes();
    test_ack_timeout();
    test_backpressure();
    test_slow_timing();

    settle();
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
